/* rtl/vrm_pkg.sv */
package vrm_pkg;

  localparam int unsigned SpriteMemBytes     = 256;
  localparam int unsigned NametableBankBytes = 1024;
  localparam int unsigned PatternBytes       = 8192;
  localparam int unsigned PaletteBytes       = 32;

  localparam int unsigned OamAw = $clog2(SpriteMemBytes);
  localparam int unsigned NtAw  = $clog2(2 * NametableBankBytes);
  localparam int unsigned PatAw = $clog2(PatternBytes);
  localparam int unsigned PalAw = $clog2(PaletteBytes);
  localparam int unsigned VramAw = 14;

  localparam logic [1:0] MIRROR_HORIZ = 2'd0;
  localparam logic [1:0] MIRROR_VERT  = 2'd1;

  localparam logic [5:0] PAL_PAGE  = 6'h3F;
  localparam logic [7:0] PAL_MASK  = 8'h3F;
  localparam logic [7:0] GRAY_MASK = 8'h30;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_PEEK      = 3'd1,
    ACT_WRITE     = 3'd2,
    ACT_VBLANK    = 3'd3,
    ACT_PRERENDER = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_CTRL    = 3'd0,
    REG_MASK    = 3'd1,
    REG_STATUS  = 3'd2,
    REG_OAMADDR = 3'd3,
    REG_OAMDATA = 3'd4,
    REG_SCROLL  = 3'd5,
    REG_ADDR    = 3'd6,
    REG_DATA    = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CFG_MIRROR_MODE = 1'b0,
    CFG_SINGLE_BANK = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [OamAw-1:0] addr;
    logic [7:0]       wdata;
  } oam_req_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [VramAw-1:0] addr;
    logic [7:0]        wdata;
  } vram_req_t;

endpackage

/* rtl/vrm_oam.sv */
module vrm_oam import vrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  oam_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [SpriteMemBytes];
  logic [SpriteMemBytes-1:0] valid_r;
  logic [7:0] mem_q_r;
  logic       vld_q_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.addr];
      vld_q_r <= valid_r[req.addr];
    end
  end

  assign rdata = vld_q_r ? mem_q_r : 8'h00;

endmodule

/* rtl/vrm_vram.sv */
module vrm_vram import vrm_pkg::*; (
  input  logic       clk,
  input  vram_req_t  req,
  input  logic [1:0] mirror_mode,
  input  logic       single_bank,
  input  logic       gray,
  output logic [7:0] rdata
);

  logic [7:0] pat_mem [PatternBytes];
  logic [7:0] nt_mem  [2 * NametableBankBytes];
  logic [7:0] pal_mem [PaletteBytes];

  logic             is_pat;
  logic             is_pal;
  logic             bank;
  logic [NtAw-1:0]  nt_idx;
  logic [PalAw-1:0] pal_idx;

  logic [7:0] pat_q_r;
  logic [7:0] nt_q_r;
  logic [7:0] pal_q_r;
  logic       is_pat_r;
  logic       is_pal_r;

  always_comb begin
    is_pat = !req.addr[VramAw-1];
    is_pal = (req.addr[VramAw-1:8] == PAL_PAGE);
    if (mirror_mode == MIRROR_VERT) begin
      bank = req.addr[10];
    end else if (mirror_mode == MIRROR_HORIZ) begin
      bank = req.addr[11];
    end else begin
      bank = single_bank;
    end
    nt_idx  = {bank, req.addr[NtAw-2:0]};
    pal_idx = req.addr[PalAw-1:0];
    // backdrop mirrors of sprite palettes
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && is_pat) begin
      pat_mem[req.addr[PatAw-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      pat_q_r <= pat_mem[req.addr[PatAw-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && !is_pat && !is_pal) begin
      nt_mem[nt_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      nt_q_r <= nt_mem[nt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && is_pal) begin
      pal_mem[pal_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      pal_q_r  <= pal_mem[pal_idx];
      is_pat_r <= is_pat;
      is_pal_r <= is_pal;
    end
  end

  always_comb begin
    if (is_pat_r) begin
      rdata = pat_q_r;
    end else if (is_pal_r) begin
      rdata = pal_q_r & (gray ? GRAY_MASK : PAL_MASK);
    end else begin
      rdata = nt_q_r;
    end
  end

endmodule

/* rtl/video_register_port_vram_map.sv */
// Eight-register CPU port of a video processor with loopy scroll/address
// latches, OAM with auto-increment, and internal pattern, nametable and
// palette memories. An accepted item launches the single-port memory reads
// (OAM at the OAM address, VRAM at the current address), waits in the
// execute state until the output register can take it, then applies the
// access, writes memory back and loads the result register. One item is in
// flight at a time; a new item is taken while a previous result still waits
// in the output register, and it finishes as soon as that result is taken.
// OAM reads zero until written; no clearing pass is needed after reset.
module video_register_port_vram_map import vrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_rdata,
  output logic        out_nmi_level,
  output logic        out_nmi_pulse,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state_r, state_nxt;

  logic [2:0]  act_r;
  logic [2:0]  reg_r;
  logic [7:0]  wd_r;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [14:0] t_r, t_nxt;
  logic [14:0] v_r, v_nxt;
  logic        toggle_r, toggle_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [7:0]  oam_addr_r, oam_addr_nxt;
  logic        nmi_prev_r;
  logic [1:0]  mirror_r;
  logic        single_bank_r;

  logic        out_valid_r;
  logic [7:0]  out_rdata_r;
  logic        out_level_r;
  logic        out_pulse_r;

  logic        accept;
  logic        commit;
  logic        cfg_wr;
  logic [7:0]  r_val;
  logic        level;
  logic [14:0] v_step;
  logic        oam_wr;
  logic        vram_wr;
  logic [7:0]  oam_rdata;
  logic [7:0]  vram_rdata;
  oam_req_t    oam_req;
  vram_req_t   vram_req;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;
  assign out_nmi_level = out_level_r;
  assign out_nmi_pulse = out_pulse_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r      <= MIRROR_HORIZ;
      single_bank_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(paddr[2]))
        CFG_MIRROR_MODE: mirror_r      <= pwdata[1:0];
        CFG_SINGLE_BANK: single_bank_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx_t'(paddr[2]))
      CFG_MIRROR_MODE: prdata = {30'd0, mirror_r};
      CFG_SINGLE_BANK: prdata = {31'd0, single_bank_r};
      default:         prdata = 32'd0;
    endcase
  end

  // memories
  assign oam_wr  = commit && (action_t'(act_r) == ACT_WRITE) && (reg_idx_t'(reg_r) == REG_OAMDATA);
  assign vram_wr = commit && (action_t'(act_r) == ACT_WRITE) && (reg_idx_t'(reg_r) == REG_DATA);

  always_comb begin
    oam_req.rd_en  = accept;
    oam_req.wr_en  = oam_wr;
    oam_req.addr   = oam_addr_r;
    oam_req.wdata  = wd_r;
    vram_req.rd_en = accept;
    vram_req.wr_en = vram_wr;
    vram_req.addr  = v_r[VramAw-1:0];
    vram_req.wdata = wd_r;
  end

  vrm_oam u_oam (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (oam_req),
    .rdata (oam_rdata)
  );

  vrm_vram u_vram (
    .clk         (clk),
    .req         (vram_req),
    .mirror_mode (mirror_r),
    .single_bank (single_bank_r),
    .gray        (mask_r[0]),
    .rdata       (vram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      reg_r <= in_reg_index;
      wd_r  <= in_wdata;
    end
  end

  // register update for the item in flight
  assign v_step = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    t_nxt        = t_r;
    v_nxt        = v_r;
    toggle_nxt   = toggle_r;
    rbuf_nxt     = rbuf_r;
    oam_addr_nxt = oam_addr_r;
    r_val        = 8'h00;
    case (action_t'(act_r))
      ACT_READ: begin
        case (reg_idx_t'(reg_r))
          REG_STATUS: begin
            r_val         = {status_r, rbuf_r[4:0]};
            status_nxt[2] = 1'b0;
            toggle_nxt    = 1'b0;
          end
          REG_OAMDATA: r_val = oam_rdata;
          REG_DATA: begin
            // palette reads bypass the buffer
            r_val    = (v_r[13:8] == PAL_PAGE) ? vram_rdata : rbuf_r;
            rbuf_nxt = vram_rdata;
            v_nxt    = v_step;
          end
          default: ;
        endcase
      end
      ACT_PEEK: begin
        case (reg_idx_t'(reg_r))
          REG_CTRL:   r_val = ctrl_r;
          REG_MASK:   r_val = mask_r;
          REG_STATUS: r_val = {status_r, 5'd0};
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (reg_idx_t'(reg_r))
          REG_CTRL: begin
            ctrl_nxt = wd_r;
            t_nxt    = {t_r[14:12], wd_r[1:0], t_r[9:0]};
          end
          REG_MASK:    mask_nxt     = wd_r;
          REG_OAMADDR: oam_addr_nxt = wd_r;
          REG_OAMDATA: oam_addr_nxt = oam_addr_r + 8'd1;
          REG_SCROLL: begin
            if (!toggle_r) begin
              t_nxt = {t_r[14:5], wd_r[7:3]};
            end else begin
              t_nxt = {wd_r[2:0], t_r[11:10], wd_r[7:3], t_r[4:0]};
            end
            toggle_nxt = !toggle_r;
          end
          REG_ADDR: begin
            if (!toggle_r) begin
              t_nxt = {1'b0, wd_r[5:0], t_r[7:0]};
            end else begin
              t_nxt = {t_r[14:8], wd_r};
              v_nxt = {t_r[14:8], wd_r};
            end
            toggle_nxt = !toggle_r;
          end
          REG_DATA: v_nxt = v_step;
          default: ;
        endcase
      end
      ACT_VBLANK:    status_nxt[2] = 1'b1;
      ACT_PRERENDER: status_nxt    = 3'd0;
      default: ;
    endcase
    level = ctrl_nxt[7] && status_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      mask_r     <= '0;
      status_r   <= '0;
      t_r        <= '0;
      v_r        <= '0;
      toggle_r   <= 1'b0;
      rbuf_r     <= '0;
      oam_addr_r <= '0;
      nmi_prev_r <= 1'b0;
    end else if (commit) begin
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      status_r   <= status_nxt;
      t_r        <= t_nxt;
      v_r        <= v_nxt;
      toggle_r   <= toggle_nxt;
      rbuf_r     <= rbuf_nxt;
      oam_addr_r <= oam_addr_nxt;
      nmi_prev_r <= level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rdata_r <= r_val;
      out_level_r <= level;
      out_pulse_r <= level && !nmi_prev_r;
    end
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vrm_pkg::*;

  localparam logic [1:0] MIRROR_SINGLE = 2'd2;
  localparam logic [1:0] MIRROR_SPARE  = 2'd3;
  localparam logic [2:0] ACT_NONE_5    = 3'd5;
  localparam logic [2:0] ACT_NONE_7    = 3'd7;
  localparam int CTRL_INC_BIT  = 2;
  localparam int CTRL_NMI_BIT  = 7;
  localparam int MASK_GRAY_BIT = 0;
  localparam int VBLANK_FLAG   = 2;
  localparam logic [13:0] NT_BASE  = 14'h2000;
  localparam logic [13:0] PAL_BASE = 14'h3F00;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic [7:0] rdata;
    logic       nmi_level;
    logic       nmi_pulse;
  } port_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [2:0]  in_reg_index;
  logic [7:0]  in_wdata;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_rdata;
  logic        out_nmi_level;
  logic        out_nmi_pulse;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  video_register_port_vram_map dut (.*);

  // port state as the cpu sees it
  logic [1:0]  mirror_cfg      = MIRROR_HORIZ;
  logic        single_bank_cfg = 1'b0;
  logic [7:0]  ctrl_q          = 8'h00;
  logic [7:0]  mask_q          = 8'h00;
  logic [2:0]  stat_flags      = 3'b000;
  logic [14:0] t_addr          = 15'h0000;
  logic [14:0] v_addr          = 15'h0000;
  logic [2:0]  fine_x          = 3'b000;
  logic        latch_second    = 1'b0;
  logic [7:0]  data_buf        = 8'h00;
  logic [7:0]  oam_ptr         = 8'h00;
  logic        nmi_prev        = 1'b0;
  logic [7:0]  oam_mem [SpriteMemBytes];
  logic [7:0]  pat_mem [PatternBytes];
  logic [7:0]  nt_mem  [2*NametableBankBytes];
  logic [7:0]  pal_mem [PaletteBytes];
  bit          pat_seen [PatternBytes];
  bit          nt_seen  [2*NametableBankBytes];
  bit          pal_seen [PaletteBytes];

  port_result_t port_results_due[$];
  int error_count    = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [2:0] rand_reg();
    return 3'($urandom_range(7));
  endfunction

  function automatic logic [10:0] nt_slot(input logic [13:0] a);
    logic bank;
    if (mirror_cfg == MIRROR_VERT) begin
      bank = a[10];
    end else if (mirror_cfg == MIRROR_HORIZ) begin
      bank = a[11];
    end else begin
      bank = single_bank_cfg;
    end
    return {bank, a[9:0]};
  endfunction

  // backdrop entries of the sprite palettes fold onto the background ones
  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    logic [4:0] p;
    p = a[4:0];
    if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
    return p;
  endfunction

  function automatic bit vram_known(input logic [13:0] a);
    if (a < NT_BASE) return pat_seen[a[12:0]];
    if (a < PAL_BASE) return nt_seen[nt_slot(a)];
    return pal_seen[pal_slot(a)];
  endfunction

  function automatic logic [7:0] vram_fetch(input logic [13:0] a);
    if (a < NT_BASE) return pat_mem[a[12:0]];
    if (a < PAL_BASE) return nt_mem[nt_slot(a)];
    return pal_mem[pal_slot(a)] & (mask_q[MASK_GRAY_BIT] ? GRAY_MASK : PAL_MASK);
  endfunction

  function automatic void vram_store(input logic [13:0] a, input logic [7:0] d);
    if (a < NT_BASE) begin
      pat_mem[a[12:0]] = d;
      pat_seen[a[12:0]] = 1'b1;
    end else if (a < PAL_BASE) begin
      nt_mem[nt_slot(a)] = d;
      nt_seen[nt_slot(a)] = 1'b1;
    end else begin
      pal_mem[pal_slot(a)] = d;
      pal_seen[pal_slot(a)] = 1'b1;
    end
  endfunction

  function automatic port_result_t next_port_result(input logic [2:0] act,
                                                    input logic [2:0] idx,
                                                    input logic [7:0] d);
    port_result_t res;
    logic [13:0]  a;
    logic [14:0]  stride;
    res = '0;
    a = v_addr[13:0];
    stride = ctrl_q[CTRL_INC_BIT] ? 15'd32 : 15'd1;
    case (act)
      ACT_READ: begin
        if (idx == REG_STATUS) begin
          res.rdata = {stat_flags, data_buf[4:0]};
          stat_flags[VBLANK_FLAG] = 1'b0;
          latch_second = 1'b0;
        end else if (idx == REG_OAMDATA) begin
          res.rdata = oam_mem[oam_ptr];
        end else if (idx == REG_DATA) begin
          res.rdata = data_buf;
          data_buf = vram_fetch(a);
          if (a >= PAL_BASE) res.rdata = data_buf;
          v_addr = v_addr + stride;
        end
      end
      ACT_PEEK: begin
        if (idx == REG_CTRL) begin
          res.rdata = ctrl_q;
        end else if (idx == REG_MASK) begin
          res.rdata = mask_q;
        end else if (idx == REG_STATUS) begin
          res.rdata = {stat_flags, 5'b00000};
        end
      end
      ACT_WRITE: begin
        case (idx)
          REG_CTRL: begin
            ctrl_q = d;
            t_addr[11:10] = d[1:0];
          end
          REG_MASK: mask_q = d;
          REG_OAMADDR: oam_ptr = d;
          REG_OAMDATA: begin
            oam_mem[oam_ptr] = d;
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!latch_second) begin
              t_addr[4:0] = d[7:3];
              fine_x = d[2:0];
            end else begin
              t_addr[14:12] = d[2:0];
              t_addr[9:5] = d[7:3];
            end
            latch_second = ~latch_second;
          end
          REG_ADDR: begin
            if (!latch_second) begin
              t_addr[14:8] = {1'b0, d[5:0]};
            end else begin
              t_addr[7:0] = d;
              v_addr = t_addr;
            end
            latch_second = ~latch_second;
          end
          REG_DATA: begin
            vram_store(a, d);
            v_addr = v_addr + stride;
          end
          default: ;
        endcase
      end
      ACT_VBLANK: stat_flags[VBLANK_FLAG] = 1'b1;
      ACT_PRERENDER: stat_flags = 3'b000;
      default: ;
    endcase
    res.nmi_level = ctrl_q[CTRL_NMI_BIT] & stat_flags[VBLANK_FLAG];
    res.nmi_pulse = res.nmi_level & ~nmi_prev;
    nmi_prev = res.nmi_level;
    return res;
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    port_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (port_results_due.size() == 0) begin
        log_error($sformatf("unexpected item: rdata=%h level=%b pulse=%b",
                            out_rdata, out_nmi_level, out_nmi_pulse));
      end else begin
        want = port_results_due.pop_front();
        if (want.rdata !== out_rdata || want.nmi_level !== out_nmi_level ||
            want.nmi_pulse !== out_nmi_pulse) begin
          log_error($sformatf({"mismatch: expected rdata=%h level=%b pulse=%b, ",
                               "got rdata=%h level=%b pulse=%b"},
                              want.rdata, want.nmi_level, want.nmi_pulse,
                              out_rdata, out_nmi_level, out_nmi_pulse));
        end
      end
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [2:0] idx,
                           input logic [7:0] d);
    // never let the buffer refill from memory that holds nothing yet
    if (act == ACT_READ && idx == REG_DATA && !vram_known(v_addr[13:0])) act = ACT_WRITE;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_reg_index <= idx;
    in_wdata     <= d;
    do @(posedge clk); while (!in_ready);
    port_results_due.push_back(next_port_result(act, idx, d));
    items_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (port_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_idx_t idx, input logic [31:0] value);
    wait_until_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == CFG_MIRROR_MODE) begin
      mirror_cfg = value[1:0];
    end else begin
      single_bank_cfg = value[0];
    end
  endtask

  task automatic set_mirroring(input logic [1:0] mode, input logic bank);
    logic [31:0] value;
    value = $urandom;
    value[1:0] = mode;
    write_config(CFG_MIRROR_MODE, value);
    value = $urandom;
    value[0] = bank;
    write_config(CFG_SINGLE_BANK, value);
  endtask

  task automatic point_vram_at(input logic [13:0] a);
    send_item(ACT_READ, REG_STATUS, rand_byte());
    send_item(ACT_WRITE, REG_ADDR, {2'($urandom_range(3)), a[13:8]});
    send_item(ACT_WRITE, REG_ADDR, a[7:0]);
  endtask

  function automatic logic [13:0] random_vram_address();
    case ($urandom_range(2))
      0: return 14'($urandom_range(14'h1FFF));
      1: return 14'($urandom_range(14'h3EFF, 14'h2000));
      default: return 14'($urandom_range(14'h3FFF, 14'h3F00));
    endcase
  endfunction

  task automatic run_vram_burst(input logic [13:0] a, input int n);
    point_vram_at(a);
    repeat (n) send_item(ACT_WRITE, REG_DATA, rand_byte());
    point_vram_at(a);
    repeat (n + 1) send_item(ACT_READ, REG_DATA, rand_byte());
  endtask

  // write one nametable, read back through a mirrored address
  task automatic run_nametable_alias(input int n);
    logic [13:0] a;
    logic [13:0] mirror_a;
    a = NT_BASE + 14'($urandom_range(12'hEFF));
    mirror_a = a ^ {2'b00, 2'($urandom_range(3, 1)), 10'b0};
    if ($urandom_range(1) && mirror_a < 14'h2F00) mirror_a = mirror_a + 14'h1000;
    point_vram_at(a);
    repeat (n) send_item(ACT_WRITE, REG_DATA, rand_byte());
    point_vram_at(mirror_a);
    repeat (n + 1) send_item(ACT_READ, REG_DATA, rand_byte());
  endtask

  task automatic run_oam_sequence();
    logic [7:0] p;
    int n;
    p = rand_byte();
    n = $urandom_range(6, 1);
    send_item(ACT_WRITE, REG_OAMADDR, p);
    repeat (n) send_item(ACT_WRITE, REG_OAMDATA, rand_byte());
    for (int k = 0; k < n; k++) begin
      send_item(ACT_WRITE, REG_OAMADDR, p + 8'(k));
      send_item(ACT_READ, REG_OAMDATA, rand_byte());
    end
  endtask

  // a scroll write then an address write loads v with fine y in the top bits
  task automatic run_scroll_sequence();
    send_item(ACT_READ, REG_STATUS, rand_byte());
    send_item(ACT_WRITE, REG_SCROLL, rand_byte());
    send_item(ACT_WRITE, REG_SCROLL, rand_byte());
    if ($urandom_range(1)) begin
      send_item(ACT_WRITE, REG_SCROLL, rand_byte());
      send_item(ACT_WRITE, REG_ADDR, rand_byte());
      repeat ($urandom_range(3, 1)) send_item(3'($urandom_range(2)), REG_DATA, rand_byte());
    end
  endtask

  task automatic run_nmi_sequence();
    repeat ($urandom_range(8, 3)) begin
      case ($urandom_range(5))
        0: send_item(ACT_VBLANK, rand_reg(), rand_byte());
        1: send_item(ACT_PRERENDER, rand_reg(), rand_byte());
        2: send_item(ACT_READ, REG_STATUS, rand_byte());
        3: send_item(ACT_PEEK, rand_reg(), rand_byte());
        4: send_item(ACT_WRITE, REG_CTRL, rand_byte());
        default: send_item(ACT_WRITE, REG_MASK, rand_byte());
      endcase
    end
  endtask

  task automatic run_random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      if ($urandom_range(1)) send_item(ACT_WRITE, REG_CTRL, rand_byte());
      run_vram_burst(random_vram_address(), $urandom_range(8, 1));
    end else if (pick < 45) begin
      run_nametable_alias($urandom_range(6, 1));
    end else if (pick < 60) begin
      run_oam_sequence();
    end else if (pick < 70) begin
      run_scroll_sequence();
    end else if (pick < 85) begin
      run_nmi_sequence();
    end else begin
      repeat ($urandom_range(4, 1)) send_item(3'($urandom_range(7)), rand_reg(), rand_byte());
    end
  endtask

  task automatic test_directed_cases();
    send_item(ACT_PEEK, REG_CTRL, 8'h00);
    send_item(ACT_WRITE, REG_CTRL, 8'hFF);
    send_item(ACT_PEEK, REG_CTRL, 8'h00);
    send_item(ACT_WRITE, REG_MASK, 8'h01);
    send_item(ACT_PEEK, REG_MASK, 8'hFF);
    send_item(ACT_VBLANK, REG_CTRL, 8'h00);
    send_item(ACT_VBLANK, REG_DATA, 8'hFF);
    send_item(ACT_WRITE, REG_STATUS, 8'hFF);
    send_item(ACT_READ, REG_STATUS, 8'h00);
    send_item(ACT_PRERENDER, REG_CTRL, 8'h00);
    send_item(ACT_WRITE, REG_CTRL, 8'h00);
    send_item(ACT_NONE_5, REG_DATA, 8'h00);
    send_item(ACT_NONE_7, REG_CTRL, 8'hFF);
    send_item(ACT_PEEK, REG_DATA, 8'h00);
    send_item(ACT_READ, REG_CTRL, 8'h00);
    // oam pointer wraps past the last entry
    send_item(ACT_WRITE, REG_OAMADDR, 8'hFF);
    send_item(ACT_WRITE, REG_OAMDATA, 8'h80);
    send_item(ACT_WRITE, REG_OAMADDR, 8'hFF);
    send_item(ACT_READ, REG_OAMDATA, 8'h00);
    // sprite backdrop alias, read back in greyscale
    send_item(ACT_WRITE, REG_ADDR, 8'h3F);
    send_item(ACT_WRITE, REG_ADDR, 8'h10);
    send_item(ACT_WRITE, REG_DATA, 8'h3A);
    send_item(ACT_WRITE, REG_ADDR, 8'h3F);
    send_item(ACT_WRITE, REG_ADDR, 8'h00);
    send_item(ACT_READ, REG_DATA, 8'h00);
    send_item(ACT_WRITE, REG_MASK, 8'h00);
  endtask

  task automatic test_mirroring_modes();
    send_idle_pct = 6;
    recv_stall_pct = 6;
    for (int m = 0; m < 6; m++) begin
      case (m)
        0: set_mirroring(MIRROR_HORIZ, 1'b1);
        1: set_mirroring(MIRROR_VERT, 1'b0);
        2: set_mirroring(MIRROR_SINGLE, 1'b0);
        3: set_mirroring(MIRROR_SINGLE, 1'b1);
        4: set_mirroring(MIRROR_SPARE, 1'b1);
        default: set_mirroring(MIRROR_SPARE, 1'b0);
      endcase
      repeat (4) run_nametable_alias($urandom_range(4, 1));
      run_vram_burst(random_vram_address(), $urandom_range(4, 1));
    end
  endtask

  task automatic test_receiver_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_until_drained();
    hold_left = 300;
    repeat (12) run_random_sequence();
    wait_until_drained();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_stall_pct = 59;
    repeat (6) run_random_sequence();
    wait_until_drained();
    repeat (6) run_random_sequence();
  endtask

  task automatic test_random_traffic();
    int phase_end;
    for (int phase = 0; phase < 8; phase++) begin
      set_mirroring(2'($urandom_range(3)), 1'($urandom_range(1)));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) run_random_sequence();
    end
  endtask

  initial begin
    int drain_cycles;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_READ;
    in_reg_index <= REG_CTRL;
    in_wdata     <= 8'h00;
    out_ready    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    foreach (oam_mem[i]) oam_mem[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_mirroring_modes();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_traffic();

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (port_results_due.size() != 0 && drain_cycles < 10000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && port_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
